// File: src/handshake_serial_link_transceiver_defines.svh
// Assertion macros for the serial link transceiver
`ifndef HANDSHAKE_SERIAL_LINK_TRANSCEIVER_DEFINES_SVH
`define HANDSHAKE_SERIAL_LINK_TRANSCEIVER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define HSL_ASSERT_IMPL(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define HSL_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: src/hsl_pkg.sv
// Types, codes and helpers shared by the serial link transceiver
`default_nettype none

package hsl_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_RX_REQ  = 2'd1;
    localparam logic [1:0] KIND_TX_REQ  = 2'd2;
    localparam logic [1:0] KIND_PAYLOAD = 2'd3;

    // engine modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RX   = 2'd1;
    localparam logic [1:0] MODE_TX   = 2'd2;

    // send phases; one to four are the bit-pair steps
    localparam logic [2:0] PH_TX_START = 3'd0;
    localparam logic [2:0] PH_PAIR_1   = 3'd1;
    localparam logic [2:0] PH_PAIR_4   = 3'd4;
    localparam logic [2:0] PH_TX_NEED  = 3'd5;
    localparam logic [2:0] PH_TX_END   = 3'd6;

    // receive phases
    localparam logic [2:0] PH_RX_WAIT = 3'd0;
    localparam logic [2:0] PH_RX_ACK  = 3'd1;

    // header progress
    localparam logic [1:0] HDR_LENGTH  = 2'd0;
    localparam logic [1:0] HDR_MARKER  = 2'd1;
    localparam logic [1:0] HDR_PAYLOAD = 2'd2;

    localparam logic [3:0] RX_BITS = 4'd8;

    typedef struct packed {
        logic [1:0] kind;
        logic       atn_level;
        logic       clock_level;
        logic       data_level;
        logic [7:0] value;
        logic [7:0] marker;
    } t_in_item;

    typedef struct packed {
        logic       clock_release;
        logic       data_release;
        logic [7:0] rx_byte;
        logic       rx_done;
        logic       rx_aborted;
        logic       tx_need_byte;
        logic       tx_done;
        logic       busy_res;
    } t_out_item;

    // clock and data bit of one pair step: 7/5, 6/4, 3/1, 2/0
    function automatic logic [1:0] pair_bits(input logic [7:0] shift, input logic [1:0] step);
        logic [1:0] bits;
        case (step)
            2'd0:    bits = {shift[7], shift[5]};
            2'd1:    bits = {shift[6], shift[4]};
            2'd2:    bits = {shift[3], shift[1]};
            2'd3:    bits = {shift[2], shift[0]};
            default: bits = 2'b11;
        endcase
        return bits;
    endfunction

endpackage

`default_nettype wire

// File: src/hsl_if.sv
// Valid/ready channels for request beats and result beats
`default_nettype none

interface hsl_item_if import hsl_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsl_result_if import hsl_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/hsl_core.sv
// Link engine state and the single-step update for one beat
`default_nettype none

module hsl_core import hsl_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire t_in_item  i_item,
    output t_out_item      o_result
);

    logic [1:0] r_mode,   n_mode;
    logic [2:0] r_phase,  n_phase;
    logic [3:0] r_bits,   n_bits;
    logic [7:0] r_rx_sh,  n_rx_sh;
    logic [7:0] r_tx_sh,  n_tx_sh;
    logic [8:0] r_left,   n_left;
    logic [1:0] r_hdr,    n_hdr;
    logic [7:0] r_marker, n_marker;
    logic       r_clk_drv, n_clk_drv;
    logic       r_dat_drv, n_dat_drv;

    logic [3:0] bits_inc;
    logic [1:0] pair;

    assign bits_inc = r_bits + 4'd1;
    assign pair     = pair_bits(r_tx_sh, 2'(r_phase - PH_PAIR_1));

    // next state and result for the beat in the input register
    always_comb begin
        n_mode    = (r_mode == MODE_RX || r_mode == MODE_TX) ? r_mode : MODE_IDLE;
        n_phase   = r_phase;
        n_bits    = r_bits;
        n_rx_sh   = r_rx_sh;
        n_tx_sh   = r_tx_sh;
        n_left    = r_left;
        n_hdr     = r_hdr;
        n_marker  = r_marker;
        n_clk_drv = r_clk_drv;
        n_dat_drv = r_dat_drv;
        o_result  = '0;

        case (i_item.kind)
            KIND_TICK: begin
                if (n_mode == MODE_RX) begin
                    if (!i_item.atn_level) begin
                        // attention pulled: abort, drives untouched
                        n_mode              = MODE_IDLE;
                        n_phase             = PH_RX_WAIT;
                        o_result.rx_aborted = 1'b1;
                    end else if (r_phase == PH_RX_WAIT) begin
                        if (!(i_item.clock_level && i_item.data_level)) begin
                            n_rx_sh = {~i_item.data_level, r_rx_sh[7:1]};
                            if (i_item.data_level) begin
                                n_dat_drv = 1'b0;
                            end else begin
                                n_clk_drv = 1'b0;
                            end
                            n_phase = PH_RX_ACK;
                        end
                    end else begin
                        if (i_item.clock_level || i_item.data_level) begin
                            if (bits_inc >= RX_BITS) begin
                                o_result.rx_byte = r_rx_sh;
                                o_result.rx_done = 1'b1;
                                n_mode  = MODE_IDLE;
                                n_phase = PH_RX_WAIT;
                                n_bits  = '0;
                            end else begin
                                n_bits    = bits_inc;
                                n_clk_drv = 1'b1;
                                n_dat_drv = 1'b1;
                                n_phase   = PH_RX_WAIT;
                            end
                        end
                    end
                end else if (n_mode == MODE_TX) begin
                    if (r_phase == PH_TX_START) begin
                        if (!i_item.atn_level) begin
                            n_clk_drv = 1'b0;
                            n_dat_drv = 1'b0;
                            n_phase   = PH_PAIR_1;
                        end
                    end else if (r_phase >= PH_PAIR_1 && r_phase <= PH_PAIR_4) begin
                        // odd steps wait for attention high, even ones for low
                        if (i_item.atn_level == r_phase[0]) begin
                            n_clk_drv = pair[1];
                            n_dat_drv = pair[0];
                            if (r_phase != PH_PAIR_4) begin
                                n_phase = r_phase + 3'd1;
                            end else if (r_hdr == HDR_LENGTH) begin
                                n_tx_sh = ~r_marker;
                                n_hdr   = HDR_MARKER;
                                n_phase = PH_PAIR_1;
                            end else begin
                                n_hdr   = HDR_PAYLOAD;
                                n_phase = (r_left != '0) ? PH_TX_NEED : PH_TX_END;
                            end
                        end
                    end else if (r_phase == PH_TX_END) begin
                        if (i_item.atn_level) begin
                            n_clk_drv        = 1'b0;
                            n_dat_drv        = 1'b0;
                            n_mode           = MODE_IDLE;
                            n_phase          = PH_TX_START;
                            n_hdr            = HDR_LENGTH;
                            o_result.tx_done = 1'b1;
                        end
                    end
                end
            end
            KIND_RX_REQ: begin
                if (n_mode == MODE_IDLE) begin
                    n_mode    = MODE_RX;
                    n_phase   = PH_RX_WAIT;
                    n_bits    = '0;
                    n_rx_sh   = '0;
                    n_clk_drv = 1'b1;
                    n_dat_drv = 1'b1;
                end
            end
            KIND_TX_REQ: begin
                if (n_mode == MODE_IDLE) begin
                    n_mode    = MODE_TX;
                    n_phase   = PH_TX_START;
                    n_hdr     = HDR_LENGTH;
                    n_left    = {1'b0, i_item.value};
                    n_marker  = i_item.marker;
                    n_tx_sh   = ~(i_item.value + 8'd2);
                    n_clk_drv = 1'b1;
                    n_dat_drv = 1'b1;
                end
            end
            KIND_PAYLOAD: begin
                if (n_mode == MODE_TX && r_phase == PH_TX_NEED) begin
                    n_tx_sh = ~i_item.value;
                    n_left  = r_left - 9'd1;
                    n_phase = PH_PAIR_1;
                end
            end
            default: begin
            end
        endcase

        o_result.clock_release = n_clk_drv;
        o_result.data_release  = n_dat_drv;
        o_result.tx_need_byte  = (n_mode == MODE_TX) && (n_phase == PH_TX_NEED);
        o_result.busy_res      = (n_mode != MODE_IDLE);
    end

    // engine state, advanced once per stepped beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_phase   <= '0;
            r_bits    <= '0;
            r_rx_sh   <= '0;
            r_tx_sh   <= '0;
            r_left    <= '0;
            r_hdr     <= HDR_LENGTH;
            r_marker  <= '0;
            r_clk_drv <= 1'b1;
            r_dat_drv <= 1'b1;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_phase   <= n_phase;
            r_bits    <= n_bits;
            r_rx_sh   <= n_rx_sh;
            r_tx_sh   <= n_tx_sh;
            r_left    <= n_left;
            r_hdr     <= n_hdr;
            r_marker  <= n_marker;
            r_clk_drv <= n_clk_drv;
            r_dat_drv <= n_dat_drv;
        end
    end

endmodule

`default_nettype wire

// File: src/handshake_serial_link_transceiver.sv
// An accepted beat goes from the input register to the result register; a stalled result
// side holds it in the input register. Throughput: one beat per cycle while results are
// taken; the engine step is combinational logic between the input and result registers.
// The input register refills while the result register drains, so both sides
// can run at full rate. Reset (synchronous, active low) empties both registers,
// puts the engine idle and releases the clock and data drives.
`default_nettype none

`include "handshake_serial_link_transceiver_defines.svh"

module handshake_serial_link_transceiver import hsl_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    hsl_item_if.sink     i_item,
    hsl_result_if.source o_result
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      w_out_free;
    logic      w_step;
    logic      w_in_take;
    t_out_item w_result;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_step     = r_in_valid && w_out_free;
    assign w_in_take  = i_item.valid && i_item.ready;

    assign i_item.ready   = !r_in_valid || w_step;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_item;

    hsl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i_item.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    `HSL_ASSERT_NEXT(a_step_loads, w_step, r_out_valid, "stepped beat gave no result")
    `HSL_ASSERT_NEXT(a_result_held, r_out_valid && !o_result.ready, r_out_valid, "result beat dropped")
    `HSL_ASSERT_NEXT(a_item_held, r_in_valid && !w_step, r_in_valid, "request beat dropped")
    `HSL_ASSERT_IMPL(a_need_busy, r_out_valid && r_out_item.tx_need_byte, r_out_item.busy_res && !r_out_item.rx_done, "byte request while idle")

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the serial link transceiver: scripted bus traffic
`timescale 1ns / 1ps

module tb;
    import hsl_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int QUIET_TAIL  = 150;
    localparam int LONG_HOLD   = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 30;

    // Engine model and store of awaited result beats
    class link_scoreboard;
        logic [1:0] mode        = MODE_IDLE;
        logic [2:0] phase       = PH_TX_START;
        logic [3:0] bit_cnt     = '0;
        logic [7:0] rx_shift    = '0;
        logic [7:0] tx_shift    = '0;
        logic [8:0] bytes_left  = '0;
        logic [1:0] header      = HDR_LENGTH;
        logic [7:0] marker_byte = '0;
        logic       clock_drv   = 1'b1;
        logic       data_drv    = 1'b1;
        t_out_item  awaited_results[$];
        int         mismatches   = 0;
        int         results_seen = 0;

        // one engine step; returns the line drives and flags it leaves
        function t_out_item advance_engine(t_in_item it);
            t_out_item  res;
            logic [1:0] pair;
            res = '0;
            case (it.kind)
                KIND_TICK: begin
                    if (mode == MODE_RX) begin
                        if (!it.atn_level) begin
                            // ATN pulled low: give up, drives untouched
                            mode = MODE_IDLE;
                            phase = PH_RX_WAIT;
                            res.rx_aborted = 1'b1;
                        end else if (phase == PH_RX_WAIT) begin
                            if (!(it.clock_level && it.data_level)) begin
                                rx_shift = {~it.data_level, rx_shift[7:1]};
                                if (it.data_level)
                                    data_drv = 1'b0;
                                else
                                    clock_drv = 1'b0;
                                phase = PH_RX_ACK;
                            end
                        end else if (it.clock_level || it.data_level) begin
                            bit_cnt = bit_cnt + 4'd1;
                            if (bit_cnt >= RX_BITS) begin
                                res.rx_byte = rx_shift;
                                res.rx_done = 1'b1;
                                mode = MODE_IDLE;
                                phase = PH_RX_WAIT;
                                bit_cnt = '0;
                            end else begin
                                clock_drv = 1'b1;
                                data_drv = 1'b1;
                                phase = PH_RX_WAIT;
                            end
                        end
                    end else if (mode == MODE_TX) begin
                        if (phase == PH_TX_START) begin
                            if (!it.atn_level) begin
                                clock_drv = 1'b0;
                                data_drv = 1'b0;
                                phase = PH_PAIR_1;
                            end
                        end else if (phase >= PH_PAIR_1 && phase <= PH_PAIR_4) begin
                            // odd pair steps move on ATN high, even ones on ATN low
                            if (it.atn_level == phase[0]) begin
                                case (phase)
                                    PH_PAIR_1:          pair = {tx_shift[7], tx_shift[5]};
                                    PH_PAIR_1 + 3'd1:   pair = {tx_shift[6], tx_shift[4]};
                                    PH_PAIR_4 - 3'd1:   pair = {tx_shift[3], tx_shift[1]};
                                    default:            pair = {tx_shift[2], tx_shift[0]};
                                endcase
                                clock_drv = pair[1];
                                data_drv = pair[0];
                                if (phase != PH_PAIR_4) begin
                                    phase = phase + 3'd1;
                                end else if (header == HDR_LENGTH) begin
                                    tx_shift = ~marker_byte;
                                    header = HDR_MARKER;
                                    phase = PH_PAIR_1;
                                end else begin
                                    header = HDR_PAYLOAD;
                                    phase = (bytes_left != 0) ? PH_TX_NEED : PH_TX_END;
                                end
                            end
                        end else if (phase == PH_TX_END && it.atn_level) begin
                            clock_drv = 1'b0;
                            data_drv = 1'b0;
                            mode = MODE_IDLE;
                            phase = PH_TX_START;
                            header = HDR_LENGTH;
                            res.tx_done = 1'b1;
                        end
                    end
                end
                KIND_RX_REQ: begin
                    if (mode == MODE_IDLE) begin
                        mode = MODE_RX;
                        phase = PH_RX_WAIT;
                        bit_cnt = '0;
                        rx_shift = '0;
                        clock_drv = 1'b1;
                        data_drv = 1'b1;
                    end
                end
                KIND_TX_REQ: begin
                    if (mode == MODE_IDLE) begin
                        mode = MODE_TX;
                        phase = PH_TX_START;
                        header = HDR_LENGTH;
                        bytes_left = {1'b0, it.value};
                        marker_byte = it.marker;
                        tx_shift = ~(it.value + 8'd2);
                        clock_drv = 1'b1;
                        data_drv = 1'b1;
                    end
                end
                default: begin
                    if (mode == MODE_TX && phase == PH_TX_NEED) begin
                        tx_shift = ~it.value;
                        bytes_left = bytes_left - 9'd1;
                        phase = PH_PAIR_1;
                    end
                end
            endcase
            res.clock_release = clock_drv;
            res.data_release  = data_drv;
            res.tx_need_byte  = (mode == MODE_TX && phase == PH_TX_NEED);
            res.busy_res      = (mode != MODE_IDLE);
            return res;
        endfunction

        function void note_request(t_in_item it);
            awaited_results.push_back(advance_engine(it));
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("mismatch: %s", what);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with nothing awaited", results_seen));
                return;
            end
            want = awaited_results.pop_front();
            if (got.clock_release !== want.clock_release)
                flag_mismatch($sformatf("result %0d clock_release %b, expected %b",
                                        results_seen, got.clock_release, want.clock_release));
            if (got.data_release !== want.data_release)
                flag_mismatch($sformatf("result %0d data_release %b, expected %b",
                                        results_seen, got.data_release, want.data_release));
            if (got.rx_byte !== want.rx_byte)
                flag_mismatch($sformatf("result %0d rx_byte %h, expected %h",
                                        results_seen, got.rx_byte, want.rx_byte));
            if (got.rx_done !== want.rx_done)
                flag_mismatch($sformatf("result %0d rx_done %b, expected %b",
                                        results_seen, got.rx_done, want.rx_done));
            if (got.rx_aborted !== want.rx_aborted)
                flag_mismatch($sformatf("result %0d rx_aborted %b, expected %b",
                                        results_seen, got.rx_aborted, want.rx_aborted));
            if (got.tx_need_byte !== want.tx_need_byte)
                flag_mismatch($sformatf("result %0d tx_need_byte %b, expected %b",
                                        results_seen, got.tx_need_byte, want.tx_need_byte));
            if (got.tx_done !== want.tx_done)
                flag_mismatch($sformatf("result %0d tx_done %b, expected %b",
                                        results_seen, got.tx_done, want.tx_done));
            if (got.busy_res !== want.busy_res)
                flag_mismatch($sformatf("result %0d busy_res %b, expected %b",
                                        results_seen, got.busy_res, want.busy_res));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   items_sent    = 0;
    int   hold_requests = 0;
    int   cycles        = 0;
    bit   idling_on     = 1'b1;

    hsl_item_if     item_ch();
    hsl_result_if   result_ch();
    link_scoreboard sb = new;

    handshake_serial_link_transceiver dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // result side: short random stalls, plus one long hold on request
    initial begin
        int stall;
        int holds_done;
        stall = 0;
        holds_done = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall > 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else if (holds_done < hold_requests) begin
                holds_done++;
                stall = LONG_HOLD - 1;
                result_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 9) < 2) begin
                stall = $urandom_range(0, 3);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // check every result beat taken
    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic t_in_item beat_of(input logic [1:0] kind, input logic atn_l,
                                         input logic clock_l, input logic data_l,
                                         input logic [7:0] value, input logic [7:0] mark);
        t_in_item beat;
        beat.kind        = kind;
        beat.atn_level   = atn_l;
        beat.clock_level = clock_l;
        beat.data_level  = data_l;
        beat.value       = value;
        beat.marker      = mark;
        return beat;
    endfunction

    // offer one beat, with an occasional gap first; returns at the accepting edge
    task automatic send_beat(input t_in_item beat);
        int gap;
        // no idling in the last stretch of the run
        if (items_sent >= ITEM_TARGET - QUIET_TAIL)
            idling_on = 1'b0;
        if (idling_on && chance(20)) begin
            gap = $urandom_range(1, 4);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= beat;
        do @(posedge clk); while (!item_ch.ready);
        sb.note_request(beat);
        items_sent++;
    endtask

    task automatic line_tick(input logic atn_l, input logic clock_l, input logic data_l);
        send_beat(beat_of(KIND_TICK, atn_l, clock_l, data_l, 8'($urandom), 8'($urandom)));
    endtask

    // a request the engine should ignore where it stands
    task automatic stray_request(input bit with_payload);
        logic [1:0] kind;
        kind = (with_payload && coin()) ? KIND_PAYLOAD : (coin() ? KIND_RX_REQ : KIND_TX_REQ);
        send_beat(beat_of(kind, coin(), coin(), coin(), 8'($urandom), 8'($urandom)));
    endtask

    // wait with the input quiet until every awaited beat has come back
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (sb.awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // one byte in from the bus, eight bits of sample and acknowledge; may abort on ATN
    task automatic receive_byte();
        int         abort_at;
        logic       dat;
        logic [1:0] ack;
        abort_at = chance(20) ? $urandom_range(0, 15) : -1;
        send_beat(beat_of(KIND_RX_REQ, coin(), coin(), coin(), 8'($urandom), 8'($urandom)));
        for (int b = 0; b < 8; b++) begin
            if (chance(25))
                line_tick(1'b1, 1'b1, 1'b1);
            if (chance(10))
                stray_request(1'b1);
            if (abort_at == 2 * b) begin
                line_tick(1'b0, coin(), coin());
                return;
            end
            dat = coin();
            line_tick(1'b1, dat ? 1'b0 : coin(), dat);
            if (chance(25))
                line_tick(1'b1, 1'b0, 1'b0);
            if (abort_at == 2 * b + 1) begin
                line_tick(1'b0, coin(), coin());
                return;
            end
            ack = 2'($urandom_range(1, 3));
            line_tick(1'b1, ack[1], ack[0]);
        end
    endtask

    // sends a block out: length, marker, payload, with the ATN levels driven by the script
    task automatic send_block(input int len, input logic [7:0] mark, input bit noisy);
        send_beat(beat_of(KIND_TX_REQ, coin(), coin(), coin(), 8'(len), mark));
        if (noisy && chance(30))
            line_tick(1'b1, coin(), coin());
        line_tick(1'b0, coin(), coin());
        for (int n = 0; n < len + 2; n++) begin
            if (n >= 2) begin
                if (noisy && chance(20))
                    line_tick(coin(), coin(), coin());
                if (noisy && chance(10))
                    stray_request(1'b0);
                send_beat(beat_of(KIND_PAYLOAD, coin(), coin(), coin(), 8'($urandom), 8'($urandom)));
            end
            for (int s = 0; s < 4; s++) begin
                if (noisy && chance(12))
                    stray_request(1'b1);
                // repeating the previous ATN level must not advance the pair
                if (noisy && chance(15))
                    line_tick(1'(s % 2), coin(), coin());
                line_tick((s % 2 == 0) ? 1'b1 : 1'b0, coin(), coin());
            end
        end
        if (noisy && chance(30))
            line_tick(1'b0, coin(), coin());
        line_tick(1'b1, coin(), coin());
    endtask

    // bus chatter while idle: no requests that would start the engine
    task automatic idle_noise();
        int count;
        count = $urandom_range(1, 5);
        repeat (count) begin
            if (chance(70))
                line_tick(coin(), coin(), coin());
            else
                send_beat(beat_of(KIND_PAYLOAD, coin(), coin(), coin(),
                                  8'($urandom), 8'($urandom)));
        end
    endtask

    // main sequence
    initial begin
        int  target;
        int  pick;
        bit  held;
        bit  drained;
        bit  long_done;
        rst_n           = 1'b0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        target    = ITEM_TARGET;
        held      = 1'b0;
        drained   = 1'b0;
        long_done = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle chatter, both bit polarities, a busy request, abort, empty block
        line_tick(1'b1, 1'b1, 1'b1);
        line_tick(1'b0, 1'b0, 1'b0);
        send_beat(beat_of(KIND_PAYLOAD, 1'b1, 1'b1, 1'b1, 8'hff, 8'hff));
        send_beat(beat_of(KIND_RX_REQ, 1'b1, 1'b1, 1'b1, 8'hff, 8'hff));
        line_tick(1'b1, 1'b1, 1'b1);
        line_tick(1'b1, 1'b1, 1'b0);
        send_beat(beat_of(KIND_TX_REQ, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
        line_tick(1'b1, 1'b0, 1'b0);
        line_tick(1'b1, 1'b1, 1'b1);
        line_tick(1'b1, 1'b0, 1'b1);
        line_tick(1'b0, 1'b1, 1'b1);
        send_block(0, 8'hff, 1'b0);

        // random traffic, mostly well-formed transfers
        while (items_sent < target) begin
            if (!held && items_sent > 40) begin
                held = 1'b1;
                hold_requests++;
            end
            if (!drained && items_sent > 80) begin
                drained = 1'b1;
                drain();
            end
            if (!long_done && items_sent > 120) begin
                // one full-length block, kept clean so it fits the item count
                long_done = 1'b1;
                send_block(254 + $urandom_range(0, 1), 8'($urandom), 1'b0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                receive_byte();
            else if (pick < 85)
                send_block(chance(85) ? $urandom_range(0, 3) : $urandom_range(4, 12),
                           chance(10) ? (coin() ? 8'h00 : 8'hff) : 8'($urandom), 1'b1);
            else
                idle_noise();
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/hsl_pkg.sv
src/hsl_if.sv
src/hsl_core.sv
src/handshake_serial_link_transceiver.sv
sim/tb.sv
